/* design/tobuf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tobuf_pkg
// Shared constants and types for the time ordered event buffer.
// ----------------------------------------------------------------------------
package tobuf_pkg;

    localparam int CAPACITY   = 1024;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int TIME_W     = 64;
    localparam int NEURON_W   = 32;
    localparam int IDX_W      = 10;
    localparam int STATUS_W   = 3;
    localparam int IDX_EXT_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;

    // OR tree over the cell row: one registered level of groups
    localparam int GROUP_SIZE = 32;
    localparam int NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

    // stream packing
    localparam int S_DATA_W   = ((TIME_W + NEURON_W + IDX_W + 7) / 8) * 8;
    localparam int M_DATA_W   = ((TIME_W + NEURON_W + CNT_W + 7) / 8) * 8;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_READ   = 1'b1;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_READ_OK   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BEYOND    = 3'd4;

    typedef struct packed {
        logic cmp_en;
        logic commit_en;
        logic valid;
        logic rd_sel;
    } cell_ctrl_t;

    typedef struct packed {
        logic                dup;
        logic [TIME_W-1:0]   rd_time;
        logic [NEURON_W-1:0] rd_neuron;
    } cell_flag_t;

endpackage

/* design/tobuf_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tobuf_cell
// One slot of the sorted row: holds an event, compares it against the
// request and shifts up toward the tail on insert.
// ----------------------------------------------------------------------------
module tobuf_cell (
    input  logic                              aclk,
    input  tobuf_pkg::cell_ctrl_t             ctrl,
    input  logic [tobuf_pkg::TIME_W-1:0]      new_time,
    input  logic [tobuf_pkg::NEURON_W-1:0]    new_neuron,
    input  logic                              prev_gt,
    input  logic [tobuf_pkg::TIME_W-1:0]      prev_time,
    input  logic [tobuf_pkg::NEURON_W-1:0]    prev_neuron,
    output logic                              gt,
    output logic [tobuf_pkg::TIME_W-1:0]      slot_time,
    output logic [tobuf_pkg::NEURON_W-1:0]    slot_neuron,
    output tobuf_pkg::cell_flag_t             flag
);

    logic [tobuf_pkg::TIME_W-1:0]   time_reg;
    logic [tobuf_pkg::NEURON_W-1:0] neuron_reg;
    logic                           gt_reg;
    tobuf_pkg::cell_flag_t          flag_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.cmp_en) begin
            // an empty slot counts as later than any time
            gt_reg            <= !ctrl.valid || (time_reg > new_time);
            flag_reg.dup      <= ctrl.valid && (time_reg == new_time)
                                 && (neuron_reg == new_neuron);
            flag_reg.rd_time   <= ctrl.rd_sel ? time_reg : '0;
            flag_reg.rd_neuron <= ctrl.rd_sel ? neuron_reg : '0;
        end
        if (ctrl.commit_en) begin
            if (prev_gt) begin
                time_reg   <= prev_time;
                neuron_reg <= prev_neuron;
            end else if (gt_reg) begin
                time_reg   <= new_time;
                neuron_reg <= new_neuron;
            end
        end
    end

    assign gt          = gt_reg;
    assign slot_time   = time_reg;
    assign slot_neuron = neuron_reg;
    assign flag        = flag_reg;

endmodule

/* design/tobuf_reduce.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tobuf_reduce
// OR tree over the cell flags: registered group level, then a final OR
// over the groups.
// ----------------------------------------------------------------------------
module tobuf_reduce (
    input  logic                  aclk,
    input  tobuf_pkg::cell_flag_t flags [tobuf_pkg::CAPACITY],
    output tobuf_pkg::cell_flag_t result
);

    tobuf_pkg::cell_flag_t group_reg  [tobuf_pkg::NUM_GROUPS];
    tobuf_pkg::cell_flag_t group_next [tobuf_pkg::NUM_GROUPS];

    always_comb begin
        for (int g = 0; g < tobuf_pkg::NUM_GROUPS; g++) begin
            group_next[g] = '0;
            for (int j = 0; j < tobuf_pkg::GROUP_SIZE; j++) begin
                if (g * tobuf_pkg::GROUP_SIZE + j < tobuf_pkg::CAPACITY) begin
                    group_next[g] = group_next[g]
                                    | flags[g * tobuf_pkg::GROUP_SIZE + j];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int g = 0; g < tobuf_pkg::NUM_GROUPS; g++) begin
            group_reg[g] <= group_next[g];
        end
    end

    always_comb begin
        result = '0;
        for (int g = 0; g < tobuf_pkg::NUM_GROUPS; g++) begin
            result = result | group_reg[g];
        end
    end

endmodule

/* design/time_ordered_event_buffer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// time_ordered_event_buffer
// Sorted row of spike events (time, neuron id) with insert and read requests.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries requests: s_tuser is the opcode (0 insert, 1 read), s_tdata
//   carries spike_time, neuron and read_index. m_* carries one result per
//   request: m_tuser is the status, m_tdata carries entry_time, entry_neuron
//   and entry_count.
//   A request passes through accept, compare in every cell, a registered
//   OR over groups of 32 cells, then commit. The result shows on m_tvalid
//   the cycle after commit, and a new request can be accepted in the cycle
//   after commit; none is taken before the last one has committed. The
//   compare across the whole cell row and its OR tree set these steps.
//   An insert shifts every later cell up by one in the commit cycle.
//   Reset clears the entry count, the state and m_tvalid; cell contents stay
//   undefined and are only read below the count. No clearing pass is needed.
//   When the receiver stalls, the result is held on m_*; one more request may
//   be accepted and then waits in the commit step until the output frees.
// ----------------------------------------------------------------------------
module time_ordered_event_buffer (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // spike_time [63:0], neuron [95:64], read_index [105:96], zero pad
    input  logic [tobuf_pkg::S_DATA_W-1:0]   s_tdata,
    // opcode [0]
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // entry_time [63:0], entry_neuron [95:64], entry_count [106:96], zero pad
    output logic [tobuf_pkg::M_DATA_W-1:0]   m_tdata,
    // status [2:0]
    output logic [tobuf_pkg::STATUS_W-1:0]   m_tuser
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_CMP    = 2'd1;
    localparam logic [1:0] ST_RED    = 2'd2;
    localparam logic [1:0] ST_COMMIT = 2'd3;

    localparam int TW = tobuf_pkg::TIME_W;
    localparam int NW = tobuf_pkg::NEURON_W;
    localparam int CW = tobuf_pkg::CNT_W;
    localparam int EW = tobuf_pkg::IDX_EXT_W;

    logic [1:0]                  state_reg, state_next;
    logic                        req_op_reg;
    logic [TW-1:0]               req_time_reg;
    logic [NW-1:0]               req_neuron_reg;
    logic [tobuf_pkg::IDX_W-1:0] req_idx_reg;
    logic [CW-1:0]               count_reg;

    logic                           m_valid_reg;
    logic [tobuf_pkg::STATUS_W-1:0] m_status_reg;
    logic [TW-1:0]                  m_time_reg;
    logic [NW-1:0]                  m_neuron_reg;
    logic [CW-1:0]                  m_count_reg;

    logic                  s_accept;
    logic                  out_free;
    logic                  commit_go;
    logic                  is_full;
    logic                  insert_ok;
    logic [EW-1:0]         idx_ext;
    logic                  rd_in_range;
    logic [tobuf_pkg::STATUS_W-1:0] status_next;
    logic [CW-1:0]         count_next;

    tobuf_pkg::cell_ctrl_t cell_ctrl   [tobuf_pkg::CAPACITY];
    tobuf_pkg::cell_flag_t cell_flag   [tobuf_pkg::CAPACITY];
    logic                  cell_gt     [tobuf_pkg::CAPACITY];
    logic [TW-1:0]         cell_time   [tobuf_pkg::CAPACITY];
    logic [NW-1:0]         cell_neuron [tobuf_pkg::CAPACITY];
    tobuf_pkg::cell_flag_t red;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign commit_go = (state_reg == ST_COMMIT) && out_free;
    assign is_full   = (count_reg == CW'(tobuf_pkg::CAPACITY));
    assign insert_ok = (req_op_reg == tobuf_pkg::OP_INSERT) && !red.dup && !is_full;
    assign idx_ext   = EW'(req_idx_reg);
    assign rd_in_range = idx_ext < EW'(count_reg);

    always_comb begin
        case (state_reg)
            ST_IDLE:   state_next = s_accept ? ST_CMP : ST_IDLE;
            ST_CMP:    state_next = ST_RED;
            ST_RED:    state_next = ST_COMMIT;
            ST_COMMIT: state_next = out_free ? ST_IDLE : ST_COMMIT;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        count_next = count_reg;
        if (req_op_reg == tobuf_pkg::OP_INSERT) begin
            if (red.dup) begin
                status_next = tobuf_pkg::ST_DUPLICATE;
            end else if (is_full) begin
                status_next = tobuf_pkg::ST_FULL;
            end else begin
                status_next = tobuf_pkg::ST_INSERTED;
                count_next  = count_reg + CW'(1);
            end
        end else if (rd_in_range) begin
            status_next = tobuf_pkg::ST_READ_OK;
        end else begin
            status_next = tobuf_pkg::ST_BEYOND;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (commit_go) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            req_op_reg     <= s_tuser;
            req_time_reg   <= s_tdata[TW-1:0];
            req_neuron_reg <= s_tdata[TW+NW-1:TW];
            req_idx_reg    <= s_tdata[TW+NW+tobuf_pkg::IDX_W-1:TW+NW];
        end
        if (commit_go) begin
            m_status_reg <= status_next;
            m_time_reg   <= (req_op_reg == tobuf_pkg::OP_READ) ? red.rd_time : '0;
            m_neuron_reg <= (req_op_reg == tobuf_pkg::OP_READ) ? red.rd_neuron : '0;
            m_count_reg  <= count_next;
        end
    end

    // cell row: each cell takes its lower neighbor's entry on shift
    for (genvar i = 0; i < tobuf_pkg::CAPACITY; i++) begin : g_cell
        logic          prev_gt;
        logic [TW-1:0] prev_time;
        logic [NW-1:0] prev_neuron;

        if (i == 0) begin : g_head
            assign prev_gt     = 1'b0;
            assign prev_time   = req_time_reg;
            assign prev_neuron = req_neuron_reg;
        end else begin : g_body
            assign prev_gt     = cell_gt[i-1];
            assign prev_time   = cell_time[i-1];
            assign prev_neuron = cell_neuron[i-1];
        end

        assign cell_ctrl[i].cmp_en    = (state_reg == ST_CMP);
        assign cell_ctrl[i].commit_en = commit_go && insert_ok;
        assign cell_ctrl[i].valid     = CW'(i) < count_reg;
        assign cell_ctrl[i].rd_sel    = (CW'(i) < count_reg) && (idx_ext == EW'(i));

        tobuf_cell u_cell (
            .aclk        (aclk),
            .ctrl        (cell_ctrl[i]),
            .new_time    (req_time_reg),
            .new_neuron  (req_neuron_reg),
            .prev_gt     (prev_gt),
            .prev_time   (prev_time),
            .prev_neuron (prev_neuron),
            .gt          (cell_gt[i]),
            .slot_time   (cell_time[i]),
            .slot_neuron (cell_neuron[i]),
            .flag        (cell_flag[i])
        );
    end

    tobuf_reduce u_reduce (
        .aclk   (aclk),
        .flags  (cell_flag),
        .result (red)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {{(tobuf_pkg::M_DATA_W - TW - NW - CW){1'b0}},
                       m_count_reg, m_neuron_reg, m_time_reg};

    // no insert may commit into a full row
    assert property (@(posedge aclk) disable iff (!aresetn)
        (commit_go && insert_ok) |-> !is_full)
        else $error("insert committed while full");

    // a result only appears out of the commit step
    assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && $rose(m_valid_reg)) |-> ($past(state_reg) == ST_COMMIT))
        else $error("result raised outside commit");

    // the count moves by one insert at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && (count_reg != $past(count_reg)))
        |-> (count_reg == $past(count_reg) + CW'(1)))
        else $error("entry count jumped");

    // an accepted request cannot finish in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !commit_go)
        else $error("request skipped compare");

endmodule
